// ----- rtl/rbb_pkg.sv -----
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared constants, register codes and types of the RGB box blur.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_RADIUS = 7;
  localparam int QUEUE_DEPTH    = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd480;
  localparam logic [2:0]  RST_WIN_RADIUS   = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_WIN_RADIUS   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ACC,
    B_FLUSH,
    B_DIV,
    B_OUT
  } back_state_t;

  // Width of one queued job: write part, window part and output position.
  function automatic int job_bits(int max_width, int max_radius);
    int col_w;
    int slot_w;
    int span_w;
    int cnt_w;
    col_w  = $clog2(max_width);
    slot_w = $clog2(2 * max_radius + 2);
    span_w = $clog2(2 * max_radius + 2);
    cnt_w  = $clog2((2 * max_radius + 1) * (2 * max_radius + 1) + 1);
    return 2 * slot_w + 3 * col_w + 2 * span_w + cnt_w + 43;
  endfunction

endpackage

// ----- rtl/rbb_pix_if.sv -----
// ----------------------------------------------------------------------------
// rbb_pix_if
// Pixel input channel: kind flag and one RGB pixel.
// ----------------------------------------------------------------------------
interface rbb_pix_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;

  modport source (output valid, kind, in_blue, in_green, in_red, input ready);
  modport sink   (input valid, kind, in_blue, in_green, in_red, output ready);
endinterface

// ----- rtl/rbb_out_if.sv -----
// ----------------------------------------------------------------------------
// rbb_out_if
// Blurred pixel output channel with its position and end-of-frame flag.
// ----------------------------------------------------------------------------
interface rbb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [10:0] out_col;
  logic [15:0] out_row;
  logic        frame_last;

  modport source (output valid, out_blue, out_green, out_red, out_col, out_row,
                  frame_last, input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_col, out_row,
                  frame_last, output ready);
endinterface

// ----- rtl/rbb_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rbb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rbb_cfg_if import rbb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/rbb_front.sv -----
// ----------------------------------------------------------------------------
// rbb_front
// Holds the configuration and the input/output raster positions, decides per
// item whether a pixel is stored and whether an output is due, and emits a job.
// ----------------------------------------------------------------------------
module rbb_front import rbb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  localparam int JOB_W     = job_bits(MAX_WIDTH, MAX_RADIUS)
) (
  input  logic             clk,
  input  logic             rst,
  rbb_pix_if.sink          pix,
  rbb_cfg_if.sink          cfg,
  output logic             job_valid,
  input  logic             job_ready,
  output logic [JOB_W-1:0] job_data
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int SLOT_W     = $clog2(STORE_ROWS);
  localparam int SPAN_W     = $clog2(2 * MAX_RADIUS + 2);
  localparam int CNT_W      = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [COL_W-1:0]  wr_col;
    logic [23:0]       pixel;
    logic              em_en;
    logic [SLOT_W-1:0] slot0;
    logic [COL_W-1:0]  col0;
    logic [SPAN_W-1:0] nrows;
    logic [SPAN_W-1:0] ncols;
    logic [CNT_W-1:0]  cnt;
    logic [COL_W-1:0]  ecol;
    logic [15:0]       erow;
    logic              last;
  } job_t;

  logic [11:0]       image_width;
  logic [15:0]       image_height;
  logic [2:0]        win_radius;
  logic [COL_W-1:0]  in_col;
  logic [15:0]       in_row;
  logic [SLOT_W-1:0] in_slot;
  logic [COL_W-1:0]  emit_col;
  logic [15:0]       emit_row;
  logic [SLOT_W-1:0] emit_slot;

  logic [COL_W:0]    w_eff;
  logic [COL_W-1:0]  wm1;
  logic [15:0]       hm1;
  logic [2:0]        rad;
  logic              ing;
  logic [COL_W-1:0]  in_col_next;
  logic [15:0]       in_row_next;
  logic [SLOT_W-1:0] in_slot_next;
  logic [16:0]       dr_ext;
  logic [COL_W:0]    dc_ext;
  logic [15:0]       dr;
  logic [COL_W-1:0]  dc;
  logic [15:0]       r0;
  logic [COL_W-1:0]  c0;
  logic [SLOT_W-1:0] rback;
  logic [SLOT_W:0]   slot_sum;
  logic              emit;
  logic              last;
  logic              accept;
  job_t              job;

  always_comb begin
    if (image_width == 12'd0) begin
      w_eff = (COL_W+1)'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W+1)'(image_width);
    end
    wm1 = COL_W'(w_eff - 1'b1);
    hm1 = (image_height == 16'd0) ? 16'd0 : image_height - 16'd1;
    rad = (32'(win_radius) > MAX_RADIUS) ? 3'(MAX_RADIUS) : win_radius;
  end

  // Ingest step
  always_comb begin
    ing          = !pix.kind && (in_row <= hm1);
    in_col_next  = in_col;
    in_row_next  = in_row;
    in_slot_next = in_slot;
    if (ing) begin
      if (in_col == wm1) begin
        in_col_next  = '0;
        in_row_next  = in_row + 16'd1;
        in_slot_next = (in_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : in_slot + 1'b1;
      end else begin
        in_col_next = in_col + 1'b1;
      end
    end
  end

  // Output readiness and window bounds
  always_comb begin
    dr_ext = {1'b0, emit_row} + 17'(rad);
    dr     = (dr_ext >= {1'b0, hm1}) ? hm1 : dr_ext[15:0];
    dc_ext = {1'b0, emit_col} + (COL_W+1)'(rad);
    dc     = (dc_ext >= {1'b0, wm1}) ? wm1 : dc_ext[COL_W-1:0];
    emit   = (emit_row <= hm1) &&
             ((in_row_next > dr) || ((in_row_next == dr) && (in_col_next > dc)));
    r0     = (emit_row > 16'(rad)) ? emit_row - 16'(rad) : 16'd0;
    c0     = (emit_col > COL_W'(rad)) ? emit_col - COL_W'(rad) : '0;
    rback  = SLOT_W'(emit_row - r0);
    if (emit_slot >= rback) begin
      slot_sum = {1'b0, emit_slot} - {1'b0, rback};
    end else begin
      slot_sum = {1'b0, emit_slot} + (SLOT_W+1)'(STORE_ROWS) - {1'b0, rback};
    end
    last   = (emit_row == hm1) && (emit_col == wm1);
  end

  always_comb begin
    job.wr_en   = ing;
    job.wr_slot = in_slot;
    job.wr_col  = in_col;
    job.pixel   = {pix.in_red, pix.in_green, pix.in_blue};
    job.em_en   = emit;
    job.slot0   = slot_sum[SLOT_W-1:0];
    job.col0    = c0;
    job.nrows   = SPAN_W'(dr - r0 + 16'd1);
    job.ncols   = SPAN_W'(dc - c0 + 1'b1);
    job.cnt     = CNT_W'(job.nrows) * CNT_W'(job.ncols);
    job.ecol    = emit_col;
    job.erow    = emit_row;
    job.last    = last;
  end

  // Hold the pixel side while a register write takes the cycle
  assign pix.ready = job_ready && !cfg.valid;
  assign cfg.ready = 1'b1;
  assign accept    = pix.valid && pix.ready;
  assign job_valid = accept && (ing || emit);
  assign job_data  = JOB_W'(job);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      win_radius   <= RST_WIN_RADIUS;
      in_col       <= '0;
      in_row       <= '0;
      in_slot      <= '0;
      emit_col     <= '0;
      emit_row     <= '0;
      emit_slot    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[11:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        REG_WIN_RADIUS:   win_radius   <= cfg.data[2:0];
        default: ;
      endcase
      if (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT ||
          cfg.index == REG_WIN_RADIUS) begin
        in_col    <= '0;
        in_row    <= '0;
        in_slot   <= '0;
        emit_col  <= '0;
        emit_row  <= '0;
        emit_slot <= '0;
      end
    end else if (accept) begin
      if (emit && last) begin
        // frame done: restart all positions
        in_col    <= '0;
        in_row    <= '0;
        in_slot   <= '0;
        emit_col  <= '0;
        emit_row  <= '0;
        emit_slot <= '0;
      end else begin
        in_col  <= in_col_next;
        in_row  <= in_row_next;
        in_slot <= in_slot_next;
        if (emit) begin
          if (emit_col == wm1) begin
            emit_col  <= '0;
            emit_row  <= emit_row + 16'd1;
            emit_slot <= (emit_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : emit_slot + 1'b1;
          end else begin
            emit_col <= emit_col + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/rbb_queue.sv -----
// ----------------------------------------------------------------------------
// rbb_queue
// Small register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module rbb_queue import rbb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             can_push,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign can_push  = (count != CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && can_push;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

endmodule

// ----- rtl/rbb_back.sv -----
// ----------------------------------------------------------------------------
// rbb_back: owns the line store. Per job: store the pixel if it carries one;
// if an output is due, sum the window one store read per cycle and divide the
// three sums by the pixel count, one bit a cycle.
// ----------------------------------------------------------------------------
module rbb_back import rbb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  localparam int JOB_W     = job_bits(MAX_WIDTH, MAX_RADIUS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  logic [JOB_W-1:0] job_data,
  rbb_out_if.source        blur
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int SLOT_W     = $clog2(STORE_ROWS);
  localparam int SPAN_W     = $clog2(2 * MAX_RADIUS + 2);
  localparam int WIN_MAX    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W      = $clog2(WIN_MAX + 1);
  localparam int SUM_W      = $clog2(WIN_MAX * 255 + 1);
  localparam int DIV_W      = $clog2(SUM_W);
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int MEM_DEPTH  = STORE_ROWS * (2 ** COL_W);

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [COL_W-1:0]  wr_col;
    logic [23:0]       pixel;
    logic              em_en;
    logic [SLOT_W-1:0] slot0;
    logic [COL_W-1:0]  col0;
    logic [SPAN_W-1:0] nrows;
    logic [SPAN_W-1:0] ncols;
    logic [CNT_W-1:0]  cnt;
    logic [COL_W-1:0]  ecol;
    logic [15:0]       erow;
    logic              last;
  } job_t;

  logic [23:0] mem [MEM_DEPTH];

  back_state_t       state;
  back_state_t       state_next;
  job_t              in_job;
  job_t              job;
  logic [SLOT_W-1:0] ys;
  logic [COL_W-1:0]  xs;
  logic [SPAN_W-1:0] yi;
  logic [SPAN_W-1:0] xi;
  logic [23:0]       rd_data;
  logic              rd_vld;
  logic [SUM_W-1:0]  sum_b;
  logic [SUM_W-1:0]  sum_g;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  rem_b;
  logic [CNT_W-1:0]  rem_g;
  logic [CNT_W-1:0]  rem_r;
  logic [DIV_W-1:0]  div_cnt;
  logic              take;
  logic              x_end;
  logic              y_end;
  logic              mem_we;

  assign in_job = job_t'(job_data);

  // One restoring division step: returns {remainder, shifted numerator}.
  function automatic logic [CNT_W+SUM_W-1:0] div_step(
    input logic [CNT_W-1:0] rem,
    input logic [SUM_W-1:0] num,
    input logic [CNT_W-1:0] den
  );
    logic [CNT_W:0] sh;
    logic           ge;
    logic [CNT_W-1:0] rem_n;
    sh    = {rem, num[SUM_W-1]};
    ge    = (sh >= {1'b0, den});
    rem_n = ge ? CNT_W'(sh - {1'b0, den}) : CNT_W'(sh);
    return {rem_n, num[SUM_W-2:0], ge};
  endfunction

  assign x_end = (xi == job.ncols - 1'b1);
  assign y_end = (yi == job.nrows - 1'b1);
  assign take  = job_valid && job_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (take && in_job.em_en) state_next = B_ACC;
      B_ACC:   if (x_end && y_end) state_next = B_FLUSH;
      B_FLUSH: state_next = B_DIV;
      B_DIV:   if (div_cnt == DIV_W'(SUM_W - 1)) state_next = B_OUT;
      B_OUT:   if (blur.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_ready       = (state == B_IDLE);
    mem_we          = take && in_job.wr_en;
    blur.valid      = (state == B_OUT);
    blur.out_blue   = sum_b[7:0];
    blur.out_green  = sum_g[7:0];
    blur.out_red    = sum_r[7:0];
    blur.out_col    = 11'(job.ecol);
    blur.out_row    = job.erow;
    blur.frame_last = job.last;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{in_job.wr_slot, in_job.wr_col}] <= in_job.pixel;
    end
    rd_data <= mem[ADDR_W'({ys, xs})];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == B_ACC);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (take) begin
          job <= in_job;
        end
        ys    <= in_job.slot0;
        xs    <= in_job.col0;
        yi    <= '0;
        xi    <= '0;
        sum_b <= '0;
        sum_g <= '0;
        sum_r <= '0;
      end
      B_ACC, B_FLUSH: begin
        if (state == B_ACC) begin
          if (x_end) begin
            xi <= '0;
            xs <= job.col0;
            yi <= yi + 1'b1;
            ys <= (ys == SLOT_W'(STORE_ROWS - 1)) ? '0 : ys + 1'b1;
          end else begin
            xi <= xi + 1'b1;
            xs <= xs + 1'b1;
          end
        end
        if (rd_vld) begin
          sum_b <= sum_b + SUM_W'(rd_data[7:0]);
          sum_g <= sum_g + SUM_W'(rd_data[15:8]);
          sum_r <= sum_r + SUM_W'(rd_data[23:16]);
        end
        rem_b   <= '0;
        rem_g   <= '0;
        rem_r   <= '0;
        div_cnt <= '0;
      end
      B_DIV: begin
        {rem_b, sum_b} <= div_step(rem_b, sum_b, job.cnt);
        {rem_g, sum_g} <= div_step(rem_g, sum_g, job.cnt);
        {rem_r, sum_r} <= div_step(rem_r, sum_r, job.cnt);
        div_cnt        <= div_cnt + 1'b1;
      end
      B_OUT: ;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (job.cnt != '0))
    else $error("division by an empty window");

  assert property (@(posedge clk) disable iff (rst)
    (state == B_ACC) |-> (xi < job.ncols && yi < job.nrows))
    else $error("window walk out of range");

  assert property (@(posedge clk) disable iff (rst)
    (state == B_FLUSH) |-> rd_vld)
    else $error("last window read lost");

endmodule

// ----- rtl/rgb_box_blur_border_normalized.sv -----
// Release: a result falls due with the item carrying pixel (r+R, c+R), clipped to
// the frame, R*W + R items after its centre pixel where unclipped; each item sends
// at most one due result, in raster order; non-pixel items send those left at the
// frame end. Each result walks its window, one line store read per cycle, then a
// bit-serial divide (SUM_W is 16 at radius 7), one job at a time; meanwhile items
// feed a 4-entry job queue, one per cycle while it has room and cfg.valid is low.
// Reset: registers to 640 x 480, radius 1, positions to zero; store not cleared.
// ----------------------------------------------------------------------------
// rgb_box_blur_border_normalized
// Raster-order RGB box blur with border-normalised window means.
// ----------------------------------------------------------------------------
module rgb_box_blur_border_normalized import rbb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic      clk,
  input  logic      rst,
  rbb_pix_if.sink   pix,
  rbb_cfg_if.sink   cfg,
  rbb_out_if.source blur
);

  localparam int JOB_W = job_bits(MAX_WIDTH, MAX_RADIUS);

  logic             f_valid;
  logic             f_ready;
  logic [JOB_W-1:0] f_data;
  logic             b_valid;
  logic             b_ready;
  logic [JOB_W-1:0] b_data;

  rbb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .cfg       (cfg),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_data  (f_data)
  );

  rbb_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_data),
    .can_push  (f_ready),
    .pop_valid (b_valid),
    .pop       (b_ready),
    .pop_data  (b_data)
  );

  rbb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job_data  (b_data),
    .blur      (blur)
  );

endmodule
